FILE: hdl/bfps_pkg.sv
// Shared constants, types and the character decoder for the program store
// and loop control block. No dependencies.
package bfps_pkg;

  // Command codes on the input channel
  localparam logic [2:0] CMD_LOAD    = 3'd0;
  localparam logic [2:0] CMD_ADVANCE = 3'd1;
  localparam logic [2:0] CMD_PUSH    = 3'd2;
  localparam logic [2:0] CMD_POP     = 3'd3;
  localparam logic [2:0] CMD_RESTART = 3'd4;
  localparam logic [2:0] CMD_SKIP    = 3'd5;

  // Stored opcodes
  localparam logic [3:0] OP_RIGHT = 4'd0;
  localparam logic [3:0] OP_LEFT  = 4'd1;
  localparam logic [3:0] OP_PLUS  = 4'd2;
  localparam logic [3:0] OP_MINUS = 4'd3;
  localparam logic [3:0] OP_OUT   = 4'd4;
  localparam logic [3:0] OP_IN    = 4'd5;
  localparam logic [3:0] OP_OPEN  = 4'd6;
  localparam logic [3:0] OP_CLOSE = 4'd7;
  localparam logic [3:0] OP_TILDE = 4'd8;
  localparam logic [3:0] OP_END   = 4'd9;
  localparam logic [3:0] OP_NONE  = 4'hF;  // not a command character

  // Source characters (ASCII)
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  // Status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_OVERFLOW  = 3'd1;
  localparam logic [2:0] STAT_UNDERFLOW = 3'd2;
  localparam logic [2:0] STAT_SKIP_END  = 3'd3;
  localparam logic [2:0] STAT_FULL      = 3'd4;

  localparam logic [7:0] RUN_MAX = 8'd255;

  // One program store entry
  typedef struct packed {
    logic [3:0] op;
    logic [7:0] cnt;
  } entry_t;

  function automatic logic [3:0] decode_char(input logic [7:0] c);
    logic [3:0] op;
    case (c)
      CH_GT:     op = OP_RIGHT;
      CH_LT:     op = OP_LEFT;
      CH_PLUS:   op = OP_PLUS;
      CH_MINUS:  op = OP_MINUS;
      CH_DOT:    op = OP_OUT;
      CH_COMMA:  op = OP_IN;
      CH_LBRACK: op = OP_OPEN;
      CH_RBRACK: op = OP_CLOSE;
      CH_TILDE:  op = OP_TILDE;
      default:   op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

FILE: hdl/bf_program_store_and_loop_control.sv
// Program store, instruction pointer and loop-address stack with a small
// sequencer around the store's write and read ports. Depends on bfps_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command and a source
//   character. Load appends decoded characters to the store, merging runs of
//   > < + - into one entry with a repeat count. Advance, push, pop, restart
//   and skip move the instruction pointer and the loop stack.
//   Output channel (out_valid_o/out_ready_i) returns one transaction per
//   command: pointer, entry at the pointer, stack depth, length and status.
//   Each command passes through an execute, a fetch and a done state; this
//   holds for advance, push, pop, a non-merging or dropped load and unused
//   codes. A merging load adds a check state (read-modify-write of the last
//   entry) and restart a wait state (stack read); skip repeats a step state
//   and a check state for each entry walked, each step being one program
//   store read and one bracket update.
//   The block takes one command at a time; ready rises with the result and
//   the next command is taken while ready is high.
//   The output register holds a result while the receiver stalls; the next
//   command is still accepted, and its result waits in the final state until
//   the output register frees up.
//   Reset clears pointer, length, stack depth and the handshake state. The
//   store and stack memories are not cleared; only written entries are used.
module bf_program_store_and_loop_control #(
  parameter int PROGRAM_DEPTH = 4096,
  parameter int STACK_DEPTH   = 64,
  localparam int AW = $clog2(PROGRAM_DEPTH + 1),
  localparam int DW = $clog2(STACK_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    cmd_i,
  input  logic [7:0]    source_char_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [AW-1:0] instr_addr_o,
  output logic [3:0]    opcode_o,
  output logic [7:0]    repeat_count_o,
  output logic [DW-1:0] stack_depth_o,
  output logic [AW-1:0] program_length_o,
  output logic [2:0]    status_o
);
  import bfps_pkg::*;

  localparam int IW  = $clog2(PROGRAM_DEPTH);
  localparam int SIW = $clog2(STACK_DEPTH);
  localparam int NW  = $clog2(PROGRAM_DEPTH + 2);
  localparam logic [AW-1:0] PROG_FULL = AW'(PROGRAM_DEPTH);
  localparam logic [DW-1:0] STK_FULL  = DW'(STACK_DEPTH);

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_EXEC      = 8'b0000_0010,
    ST_LOAD_CHK  = 8'b0000_0100,
    ST_RST_WAIT  = 8'b0000_1000,
    ST_SKIP_STEP = 8'b0001_0000,
    ST_SKIP_CHK  = 8'b0010_0000,
    ST_FETCH     = 8'b0100_0000,
    ST_DONE      = 8'b1000_0000
  } state_e;

  state_e        state_q, state_d;
  logic [2:0]    cmd_q;
  logic [7:0]    char_q;
  logic [AW-1:0] ip_q, ip_d;
  logic [AW-1:0] len_q, len_d;
  logic [DW-1:0] depth_q, depth_d;
  logic [NW-1:0] nest_q, nest_d;
  logic [2:0]    status_q, status_d;

  // Memories and their ports
  entry_t        prog_mem [PROGRAM_DEPTH];
  entry_t        prog_rdata_q;
  logic          prog_we;
  logic [IW-1:0] prog_waddr, prog_raddr;
  entry_t        prog_wdata;

  logic [AW-1:0]  stk_mem [STACK_DEPTH];
  logic [AW-1:0]  stk_rdata_q;
  logic           stk_we;
  logic [SIW-1:0] stk_waddr, stk_raddr;

  // Output register
  logic          out_valid_q;
  logic          out_load;
  logic [AW-1:0] out_addr_q;
  logic [3:0]    out_op_q;
  logic [7:0]    out_cnt_q;
  logic [DW-1:0] out_depth_q;
  logic [AW-1:0] out_len_q;
  logic [2:0]    out_status_q;

  // Helpers
  logic [3:0]    ld_op;
  logic          ld_merge;
  logic [AW-1:0] len_last;
  logic [AW-1:0] ip_inc;
  logic [DW-1:0] depth_dec;
  logic          ip_in_prog;

  assign ld_op      = decode_char(char_q);
  assign ld_merge   = (ld_op == OP_RIGHT) || (ld_op == OP_LEFT) ||
                      (ld_op == OP_PLUS)  || (ld_op == OP_MINUS);
  assign len_last   = len_q - AW'(1);
  assign ip_inc     = ip_q + AW'(1);
  assign depth_dec  = depth_q - DW'(1);
  assign ip_in_prog = (ip_q < len_q);
  assign stk_raddr  = depth_dec[SIW-1:0];
  assign stk_waddr  = depth_q[SIW-1:0];

  // Sequencer
  always_comb begin
    logic new_entry;
    new_entry  = 1'b0;
    state_d    = state_q;
    ip_d       = ip_q;
    len_d      = len_q;
    depth_d    = depth_q;
    nest_d     = nest_q;
    status_d   = status_q;
    prog_we    = 1'b0;
    prog_waddr = len_q[IW-1:0];
    prog_wdata = '0;
    prog_raddr = ip_q[IW-1:0];
    stk_we     = 1'b0;
    out_load   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d  = ST_EXEC;
          status_d = STAT_OK;
          nest_d   = NW'(1);
        end
      end
      ST_EXEC: begin
        state_d = ST_FETCH;
        case (cmd_q)
          CMD_LOAD: begin
            if (ld_op != OP_NONE) begin
              if (ld_merge && (len_q != '0)) begin
                // read the last entry to see whether the run continues
                prog_raddr = len_last[IW-1:0];
                state_d    = ST_LOAD_CHK;
              end else begin
                new_entry = 1'b1;
              end
            end
          end
          CMD_ADVANCE: begin
            if (ip_in_prog) ip_d = ip_inc;
          end
          CMD_PUSH: begin
            if (depth_q < STK_FULL) begin
              stk_we  = 1'b1;
              depth_d = depth_q + DW'(1);
            end else begin
              status_d = STAT_OVERFLOW;
            end
          end
          CMD_POP: begin
            if (depth_q != '0) depth_d = depth_dec;
            else status_d = STAT_UNDERFLOW;
          end
          CMD_RESTART: begin
            if (depth_q != '0) state_d = ST_RST_WAIT;
            else status_d = STAT_UNDERFLOW;
          end
          CMD_SKIP: begin
            state_d = ST_SKIP_STEP;
          end
          default: ;
        endcase
      end
      ST_LOAD_CHK: begin
        state_d = ST_FETCH;
        if ((prog_rdata_q.op == ld_op) && (prog_rdata_q.cnt != RUN_MAX)) begin
          prog_we        = 1'b1;
          prog_waddr     = len_last[IW-1:0];
          prog_wdata.op  = ld_op;
          prog_wdata.cnt = prog_rdata_q.cnt + 8'd1;
        end else begin
          new_entry = 1'b1;
        end
      end
      ST_RST_WAIT: begin
        ip_d    = stk_rdata_q;
        state_d = ST_FETCH;
      end
      ST_SKIP_STEP: begin
        if (nest_q == '0) begin
          state_d = ST_FETCH;
        end else if (!ip_in_prog) begin
          status_d = STAT_SKIP_END;
          state_d  = ST_FETCH;
        end else begin
          ip_d       = ip_inc;
          prog_raddr = ip_inc[IW-1:0];
          state_d    = ST_SKIP_CHK;
        end
      end
      ST_SKIP_CHK: begin
        // bracket nesting update on the entry just read
        if (ip_in_prog) begin
          if (prog_rdata_q.op == OP_OPEN) nest_d = nest_q + NW'(1);
          else if (prog_rdata_q.op == OP_CLOSE) nest_d = nest_q - NW'(1);
        end
        state_d = ST_SKIP_STEP;
      end
      ST_FETCH: begin
        prog_raddr = ip_q[IW-1:0];
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // append a fresh entry, or drop the character when the store is full
    if (new_entry) begin
      if (len_q >= PROG_FULL) begin
        status_d = STAT_FULL;
      end else begin
        prog_we        = 1'b1;
        prog_waddr     = len_q[IW-1:0];
        prog_wdata.op  = ld_op;
        prog_wdata.cnt = ld_merge ? 8'd1 : 8'd0;
        len_d          = len_q + AW'(1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ip_q        <= '0;
      len_q       <= '0;
      depth_q     <= '0;
      nest_q      <= '0;
      status_q    <= STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ip_q     <= ip_d;
      len_q    <= len_d;
      depth_q  <= depth_d;
      nest_q   <= nest_d;
      status_q <= status_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Command capture and result payload
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_valid_i) begin
      cmd_q  <= cmd_i;
      char_q <= source_char_i;
    end
    if (out_load) begin
      out_addr_q   <= ip_q;
      out_op_q     <= ip_in_prog ? prog_rdata_q.op : OP_END;
      out_cnt_q    <= ip_in_prog ? prog_rdata_q.cnt : 8'd0;
      out_depth_q  <= depth_q;
      out_len_q    <= len_q;
      out_status_q <= status_q;
    end
  end

  // Program store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (prog_we) prog_mem[prog_waddr] <= prog_wdata;
    prog_rdata_q <= prog_mem[prog_raddr];
  end

  // Loop-address stack: write at depth, read at depth - 1
  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= ip_q;
    stk_rdata_q <= stk_mem[stk_raddr];
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign instr_addr_o     = out_addr_q;
  assign opcode_o         = out_op_q;
  assign repeat_count_o   = out_cnt_q;
  assign stack_depth_o    = out_depth_q;
  assign program_length_o = out_len_q;
  assign status_o         = out_status_q;

endmodule

FILE: hdl/bfps_checker.sv
// Port-level checks for the program store and loop control block, and the
// bind that attaches them. Depends on bfps_pkg.
module bfps_checker #(
  parameter int PROGRAM_DEPTH = 4096,
  parameter int STACK_DEPTH   = 64,
  localparam int AW = $clog2(PROGRAM_DEPTH + 1),
  localparam int DW = $clog2(STACK_DEPTH + 1)
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input logic [AW-1:0] instr_addr_o,
  input logic [3:0]    opcode_o,
  input logic [7:0]    repeat_count_o,
  input logic [DW-1:0] stack_depth_o,
  input logic [AW-1:0] program_length_o,
  input logic [2:0]    status_o
);
  import bfps_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(instr_addr_o) &&
      $stable(opcode_o) && $stable(status_o))
    else $error("result changed while stalled");

  // Pointer never passes the loaded length
  a_ip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> instr_addr_o <= program_length_o)
    else $error("instruction pointer beyond program length");

  // End opcode exactly when the pointer is at the loaded length
  a_end_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((opcode_o == OP_END) == (instr_addr_o == program_length_o)))
    else $error("end opcode mismatch");

  // Only merging commands carry a repeat count
  a_count_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (repeat_count_o != 8'd0) |-> opcode_o <= OP_MINUS)
    else $error("repeat count on non-merging entry");

  // Underflow is only reported with an empty stack
  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_UNDERFLOW) |-> stack_depth_o == '0)
    else $error("underflow with non-empty stack");

endmodule

bind bf_program_store_and_loop_control bfps_checker #(
  .PROGRAM_DEPTH(PROGRAM_DEPTH),
  .STACK_DEPTH  (STACK_DEPTH)
) u_bfps_checker (.*);

FILE: verif/tb_bf_program_store_and_loop_control.sv
// Self-checking testbench for bf_program_store_and_loop_control.
// Uses bfps_pkg for command, opcode, character and status codes; a scoreboard
// class predicts each result from its own copy of the store and loop stack.
module tb_bf_program_store_and_loop_control;
  import bfps_pkg::*;

  localparam int PROG_DEPTH    = 4096;
  localparam int LOOP_DEPTH    = 64;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS   = 30;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int LONG_RUN      = 300;

  // Command codes the block ignores
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [12:0] addr;
    logic [3:0]  op;
    logic [7:0]  cnt;
    logic [6:0]  depth;
    logic [12:0] len;
    logic [2:0]  status;
  } fetch_result_t;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_CHOPPY} rx_mode_e;

  // Shadow program store and loop stack; one expected result per transaction
  class fetch_scoreboard;
    logic [3:0]    op_mem    [PROG_DEPTH];
    logic [7:0]    cnt_mem   [PROG_DEPTH];
    int unsigned   loop_addr [LOOP_DEPTH];
    int unsigned   prog_len;
    int unsigned   ip;
    int unsigned   depth;
    int unsigned   errors;
    fetch_result_t pending [$];

    function new();
      prog_len = 0;
      ip       = 0;
      depth    = 0;
      errors   = 0;
      foreach (loop_addr[k]) loop_addr[k] = 0;
    endfunction

    function logic [3:0] char_to_op(logic [7:0] ch);
      case (ch)
        CH_GT:     return OP_RIGHT;
        CH_LT:     return OP_LEFT;
        CH_PLUS:   return OP_PLUS;
        CH_MINUS:  return OP_MINUS;
        CH_DOT:    return OP_OUT;
        CH_COMMA:  return OP_IN;
        CH_LBRACK: return OP_OPEN;
        CH_RBRACK: return OP_CLOSE;
        CH_TILDE:  return OP_TILDE;
        default:   return OP_NONE;
      endcase
    endfunction

    // Append one source character, merging runs of > < + -
    function logic [2:0] append_char(logic [7:0] ch);
      logic [3:0] op;
      bit         merging;
      op = char_to_op(ch);
      if (op == OP_NONE) return STAT_OK;
      merging = (op <= OP_MINUS);
      if (merging && prog_len > 0) begin
        if (op_mem[prog_len-1] == op && cnt_mem[prog_len-1] != RUN_MAX) begin
          cnt_mem[prog_len-1] = cnt_mem[prog_len-1] + 8'd1;
          return STAT_OK;
        end
      end
      if (prog_len >= PROG_DEPTH) return STAT_FULL;
      op_mem[prog_len]  = op;
      cnt_mem[prog_len] = merging ? 8'd1 : 8'd0;
      prog_len++;
      return STAT_OK;
    endfunction

    // Walk forward to the matching close bracket
    function logic [2:0] seek_close();
      int unsigned nest;
      nest = 1;
      while (nest != 0) begin
        if (ip >= prog_len) return STAT_SKIP_END;
        ip++;
        if (ip < prog_len) begin
          if (op_mem[ip] == OP_OPEN) nest++;
          else if (op_mem[ip] == OP_CLOSE) nest--;
        end
      end
      return STAT_OK;
    endfunction

    function void note_command(logic [2:0] c, logic [7:0] ch);
      fetch_result_t r;
      logic [2:0]    st;
      st = STAT_OK;
      case (c)
        CMD_LOAD:    st = append_char(ch);
        CMD_ADVANCE: if (ip < prog_len) ip++;
        CMD_PUSH: begin
          if (depth < LOOP_DEPTH) begin
            loop_addr[depth] = ip;
            depth++;
          end else st = STAT_OVERFLOW;
        end
        CMD_POP: begin
          if (depth > 0) depth--;
          else st = STAT_UNDERFLOW;
        end
        CMD_RESTART: begin
          if (depth > 0) ip = loop_addr[depth-1];
          else st = STAT_UNDERFLOW;
        end
        CMD_SKIP: st = seek_close();
        default: ;
      endcase
      r.addr = 13'(ip);
      r.op   = OP_END;
      r.cnt  = 8'd0;
      if (ip < prog_len) begin
        r.op  = op_mem[ip];
        r.cnt = cnt_mem[ip];
      end
      r.depth  = 7'(depth);
      r.len    = 13'(prog_len);
      r.status = st;
      pending.push_back(r);
    endfunction

    function void report_field(string field, logic [12:0] want, logic [12:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_result(fetch_result_t got);
      fetch_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $error("result with no command outstanding");
        return;
      end
      want = pending.pop_front();
      if (got.addr !== want.addr)     report_field("instr_addr", want.addr, got.addr);
      if (got.op !== want.op)         report_field("opcode", want.op, got.op);
      if (got.cnt !== want.cnt)       report_field("repeat_count", want.cnt, got.cnt);
      if (got.depth !== want.depth)   report_field("stack_depth", want.depth, got.depth);
      if (got.len !== want.len)       report_field("program_length", want.len, got.len);
      if (got.status !== want.status) report_field("status", want.status, got.status);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  cmd_i;
  logic [7:0]  source_char_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [12:0] instr_addr_o;
  logic [3:0]  opcode_o;
  logic [7:0]  repeat_count_o;
  logic [6:0]  stack_depth_o;
  logic [12:0] program_length_o;
  logic [2:0]  status_o;

  fetch_scoreboard sb;
  int unsigned     burst_left;
  bit              steady;
  int unsigned     cycle_count;
  rx_mode_e        rx_mode;
  int unsigned     rx_mode_left;
  int unsigned     rx_stall_left;

  bf_program_store_and_loop_control dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .source_char_i    (source_char_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .instr_addr_o     (instr_addr_o),
    .opcode_o         (opcode_o),
    .repeat_count_o   (repeat_count_o),
    .stack_depth_o    (stack_depth_o),
    .program_length_o (program_length_o),
    .status_o         (status_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_bf_program_store_and_loop_control NOT OK");
      $finish;
    end
  end

  // Receiver back-pressure: the stall mode is picked at random and redrawn when its run ends
  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(50, 400);
    end
    rx_mode_left--;
    if (rx_stall_left != 0) begin
      out_ready_i <= 1'b0;
      rx_stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      case (rx_mode)
        RX_OPEN:  rx_stall_left = 0;
        RX_LIGHT: if ($urandom_range(0, 3) == 0) rx_stall_left = $urandom_range(1, 3);
        RX_HEAVY: rx_stall_left = $urandom_range(0, 12);
        default:  rx_stall_left = $urandom_range(0, 1);
      endcase
    end
  end

  // Monitor: check results first, then record the accepted command
  always @(posedge clk_i) begin : result_monitor
    fetch_result_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.addr   = instr_addr_o;
        got.op     = opcode_o;
        got.cnt    = repeat_count_o;
        got.depth  = stack_depth_o;
        got.len    = program_length_o;
        got.status = status_o;
        sb.check_result(got);
      end
      if (in_valid_i && in_ready_o) sb.note_command(cmd_i, source_char_i);
    end
  end

  // Sender bursts with random gaps unless steady
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (!steady && gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // Drive one transaction and wait for its acceptance
  task automatic send_cmd(input logic [2:0] c, input logic [7:0] ch);
    pace();
    in_valid_i    <= 1'b1;
    cmd_i         <= c;
    source_char_i <= ch;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic run(input logic [2:0] c);
    send_cmd(c, 8'($urandom));
  endtask

  task automatic load(input logic [7:0] ch);
    send_cmd(CMD_LOAD, ch);
  endtask

  // Hold off until every expected result has arrived
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] command_char(int unsigned k);
    case (k)
      0:       return CH_GT;
      1:       return CH_LT;
      2:       return CH_PLUS;
      3:       return CH_MINUS;
      4:       return CH_DOT;
      5:       return CH_COMMA;
      6, 9:    return CH_LBRACK;
      7, 10:   return CH_RBRACK;
      default: return CH_TILDE;
    endcase
  endfunction

  // Mixed load/fetch traffic over a growing program
  task automatic random_traffic(input int unsigned n);
    int unsigned roll;
    logic [7:0]  ch;
    logic [7:0]  last_ch;
    last_ch = CH_PLUS;
    for (int i = 0; i < n; i++) begin
      if (i % 300 == 0) steady = ($urandom_range(0, 2) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 36) begin
        if ($urandom_range(0, 99) < 15) ch = 8'($urandom);
        else if ($urandom_range(0, 1) == 0 && sb.char_to_op(last_ch) <= OP_MINUS) ch = last_ch;
        else ch = command_char($urandom_range(0, 10));
        last_ch = ch;
        load(ch);
      end
      else if (roll < 60) run(CMD_ADVANCE);
      else if (roll < 72) run(CMD_PUSH);
      else if (roll < 82) run(CMD_POP);
      else if (roll < 90) run(CMD_RESTART);
      else if (roll < 98) run(CMD_SKIP);
      else run($urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO);
    end
  endtask

  initial begin
    int unsigned room;
    int unsigned roll;
    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cmd_i         = CMD_LOAD;
    source_char_i = 8'h00;
    out_ready_i   = 1'b0;
    burst_left    = 0;
    steady        = 1'b0;
    cycle_count   = 0;
    rx_mode       = RX_OPEN;
    rx_mode_left  = 0;
    rx_stall_left = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-stack errors, end of empty program, ignored codes and characters
    run(CMD_POP);
    run(CMD_RESTART);
    run(CMD_ADVANCE);
    run(CMD_SKIP);
    run(CMD_SPARE_LO);
    run(CMD_SPARE_HI);
    load(8'h61);
    load(8'hFF);
    // every command character, a short merge and nested brackets
    load(CH_GT);
    load(CH_GT);
    load(CH_LT);
    load(CH_PLUS);
    load(CH_MINUS);
    load(CH_DOT);
    load(CH_COMMA);
    load(CH_LBRACK);
    load(CH_LBRACK);
    load(CH_RBRACK);
    load(CH_TILDE);
    load(CH_RBRACK);
    // loop: push at 0, walk to the outer bracket, skip over the nest, jump back
    run(CMD_PUSH);
    repeat (6) run(CMD_ADVANCE);
    run(CMD_SKIP);
    run(CMD_RESTART);
    run(CMD_POP);
    drain();

    // Run longer than the count field: a second entry starts
    repeat (LONG_RUN) load(CH_PLUS);
    repeat (3) load(CH_MINUS);
    drain();

    // Fill the loop stack past its depth, then empty it past zero
    repeat (LOOP_DEPTH + 1) run(CMD_PUSH);
    run(CMD_RESTART);
    repeat (LOOP_DEPTH + 1) run(CMD_POP);
    drain();

    random_traffic(RANDOM_ITEMS);
    drain();

    // Fill the store; the last entry is a merging command
    steady = 1'b1;
    room = PROG_DEPTH - sb.prog_len;
    if (room > 1) repeat (room - 1) load(CH_DOT);
    load(CH_GT);
    steady = 1'b0;
    // full store: merging into the last entry works, new entries are refused
    repeat (3) load(CH_GT);
    load(CH_LT);
    load(CH_DOT);
    load(CH_LBRACK);
    load(8'h41);
    drain();

    // Skip forward until the pointer runs off the end
    while (sb.ip < sb.prog_len) begin
      run(CMD_SKIP);
      drain();
    end
    run(CMD_SKIP);
    run(CMD_ADVANCE);
    run(CMD_PUSH);
    run(CMD_RESTART);
    for (int i = 0; i < 40; i++) begin
      roll = $urandom_range(0, 5);
      case (roll)
        0:       run(CMD_ADVANCE);
        1:       run(CMD_PUSH);
        2:       run(CMD_POP);
        3:       run(CMD_RESTART);
        4:       load(8'($urandom));
        default: run(CMD_SPARE_HI);
      endcase
    end
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_bf_program_store_and_loop_control OK");
    else
      $display("tb_bf_program_store_and_loop_control NOT OK");
    $finish;
  end

endmodule
